// File: rtl/core/ipv4_udp_header_parser_assert.svh
// Assertion macros for the IPv4/UDP header parser.
`ifndef IPV4_UDP_HEADER_PARSER_ASSERT_SVH
`define IPV4_UDP_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define IUHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define IUHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/iuhp_pkg.sv
// Constants and status codes for the IPv4/UDP header parser.
`default_nettype none
package iuhp_pkg;

  localparam int STATUS_W = 4;
  localparam int OFFSET_W = 7;

  localparam logic [7:0] UDP_PROTO  = 8'd17;
  localparam logic [3:0] IHL_MASK   = 4'hF;
  localparam logic [3:0] IP_VER4    = 4'd4;
  localparam logic [15:0] MIN_HDR   = 16'd20;
  localparam logic [15:0] UDP_HDR   = 16'd8;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_VERSION   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_IHL       = 4'd3;
  localparam logic [STATUS_W-1:0] ST_HDR_CUT   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_TOTAL_LEN = 4'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_UDP   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_UDP_LEN   = 4'd8;
  localparam logic [STATUS_W-1:0] ST_OVERRUN   = 4'd9;

endpackage
`default_nettype wire

// File: rtl/core/ipv4_udp_header_parser.sv
// IPv4/UDP header parser: byte stream in, one header summary per packet out.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_stall, data_byte,  | request in
//          | last                            |
//  out     | out_valid, out_stall, status,   | request out
//          | addresses, ports, lengths       |
//
// One byte per cycle sustained while no stall holds the input side; a byte
// is registered on acceptance and parsed from the input register, so the
// summary of a last byte is registered once that byte leaves the parse stage.
// The parse stage is a single pass of capture muxes and 16- and 17-bit compares.
// rst (synchronous) clears the parse state and both valid flags.
// A stalled result holds the input side only when a further last byte
// reaches the parse stage; other bytes keep flowing.
`default_nettype none
`include "ipv4_udp_header_parser_assert.svh"
module ipv4_udp_header_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [iuhp_pkg::STATUS_W-1:0]      status,
  output logic [31:0]                        src_address,
  output logic [31:0]                        dst_address,
  output logic [15:0]                        source_port,
  output logic [15:0]                        dest_port,
  output logic [15:0]                        total_length,
  output logic [15:0]                        udp_length,
  output logic [iuhp_pkg::OFFSET_W-1:0]      payload_offset,
  output logic [15:0]                        payload_length
);
  import iuhp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;

  // parse state
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  version_ihl_byte, version_ihl_byte_next;
  logic [15:0] total_len_reg, total_len_reg_next;
  logic [7:0]  protocol_reg, protocol_reg_next;
  logic [31:0] src_addr_reg, src_addr_reg_next;
  logic [31:0] dst_addr_reg, dst_addr_reg_next;
  logic [15:0] source_port_reg, source_port_reg_next;
  logic [15:0] dest_port_reg, dest_port_reg_next;
  logic [15:0] udp_len_reg, udp_len_reg_next;

  logic        s1_move;
  logic        out_blocked;
  logic [3:0]  words;
  logic [15:0] hdr;
  logic [15:0] pos_off;
  logic        udp_hit;
  logic [3:0]  words_c;
  logic [15:0] hdr_c;
  logic [16:0] udp_end;
  logic [STATUS_W-1:0] status_next;

  assign out_blocked = out_valid && out_stall;
  assign s1_move     = s1_valid && !(s1_last && out_blocked);
  assign in_stall    = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_data <= data_byte;
      s1_last <= last;
    end
  end

  // capture, using the byte position before this byte is counted
  always_comb begin
    words   = version_ihl_byte[3:0] & IHL_MASK;
    hdr     = {10'd0, words, 2'b00};
    pos_off = byte_count - hdr;
    udp_hit = (byte_count >= MIN_HDR) && (words >= 4'd5) &&
              (byte_count >= hdr) && (pos_off < 16'd6);

    byte_count_next       = (byte_count != COUNT_MAX) ? byte_count + 16'd1 : byte_count;
    version_ihl_byte_next = version_ihl_byte;
    total_len_reg_next    = total_len_reg;
    protocol_reg_next     = protocol_reg;
    src_addr_reg_next     = src_addr_reg;
    dst_addr_reg_next     = dst_addr_reg;
    source_port_reg_next  = source_port_reg;
    dest_port_reg_next    = dest_port_reg;
    udp_len_reg_next      = udp_len_reg;

    priority if (byte_count == 16'd0) begin
      version_ihl_byte_next = s1_data;
    end else if (byte_count == 16'd2) begin
      total_len_reg_next = {s1_data, total_len_reg[7:0]};
    end else if (byte_count == 16'd3) begin
      total_len_reg_next = {total_len_reg[15:8], s1_data};
    end else if (byte_count == 16'd9) begin
      protocol_reg_next = s1_data;
    end else if (byte_count >= 16'd12 && byte_count <= 16'd15) begin
      src_addr_reg_next = {src_addr_reg[23:0], s1_data};
    end else if (byte_count >= 16'd16 && byte_count <= 16'd19) begin
      dst_addr_reg_next = {dst_addr_reg[23:0], s1_data};
    end else begin
    end

    if (udp_hit) begin
      unique case (pos_off[2:0])
        3'd0:    source_port_reg_next = {s1_data, source_port_reg[7:0]};
        3'd1:    source_port_reg_next = {source_port_reg[15:8], s1_data};
        3'd2:    dest_port_reg_next   = {s1_data, dest_port_reg[7:0]};
        3'd3:    dest_port_reg_next   = {dest_port_reg[15:8], s1_data};
        3'd4:    udp_len_reg_next     = {s1_data, udp_len_reg[7:0]};
        default: udp_len_reg_next     = {udp_len_reg[15:8], s1_data};
      endcase
    end
  end

  // check against the state including this byte
  always_comb begin
    words_c = version_ihl_byte_next[3:0] & IHL_MASK;
    hdr_c   = {10'd0, words_c, 2'b00};
    udp_end = {1'b0, hdr_c} + {1'b0, udp_len_reg_next};
    priority if (byte_count_next < MIN_HDR) begin
      status_next = ST_SHORT;
    end else if (version_ihl_byte_next[7:4] != IP_VER4) begin
      status_next = ST_VERSION;
    end else if (words_c < 4'd5) begin
      status_next = ST_IHL;
    end else if (byte_count_next < hdr_c) begin
      status_next = ST_HDR_CUT;
    end else if (total_len_reg_next < hdr_c || total_len_reg_next > byte_count_next) begin
      status_next = ST_TOTAL_LEN;
    end else if (protocol_reg_next != UDP_PROTO) begin
      status_next = ST_NOT_UDP;
    end else if (total_len_reg_next < hdr_c + UDP_HDR) begin
      status_next = ST_NO_ROOM;
    end else if (udp_len_reg_next < UDP_HDR) begin
      status_next = ST_UDP_LEN;
    end else if (udp_end > {1'b0, total_len_reg_next}) begin
      status_next = ST_OVERRUN;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_move && s1_last)) begin
      byte_count       <= '0;
      version_ihl_byte <= '0;
      total_len_reg    <= '0;
      protocol_reg     <= '0;
      src_addr_reg     <= '0;
      dst_addr_reg     <= '0;
      source_port_reg  <= '0;
      dest_port_reg    <= '0;
      udp_len_reg      <= '0;
    end else if (s1_move) begin
      byte_count       <= byte_count_next;
      version_ihl_byte <= version_ihl_byte_next;
      total_len_reg    <= total_len_reg_next;
      protocol_reg     <= protocol_reg_next;
      src_addr_reg     <= src_addr_reg_next;
      dst_addr_reg     <= dst_addr_reg_next;
      source_port_reg  <= source_port_reg_next;
      dest_port_reg    <= dest_port_reg_next;
      udp_len_reg      <= udp_len_reg_next;
    end
  end

  // result register: zero every field but status on error
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_move && s1_last) begin
      status <= status_next;
      if (status_next == ST_OK) begin
        src_address    <= src_addr_reg_next;
        dst_address    <= dst_addr_reg_next;
        source_port    <= source_port_reg_next;
        dest_port      <= dest_port_reg_next;
        total_length   <= total_len_reg_next;
        udp_length     <= udp_len_reg_next;
        payload_offset <= hdr_c[OFFSET_W-1:0] + OFFSET_W'(UDP_HDR);
        payload_length <= udp_len_reg_next - UDP_HDR;
      end else begin
        src_address    <= '0;
        dst_address    <= '0;
        source_port    <= '0;
        dest_port      <= '0;
        total_length   <= '0;
        udp_length     <= '0;
        payload_offset <= '0;
        payload_length <= '0;
      end
    end
  end

  `IUHP_ASSERT_NEXT(a_clear_after_last, s1_move && s1_last,
    byte_count == 16'd0 && udp_len_reg == 16'd0, "parse state not cleared after last byte")
  `IUHP_ASSERT_NOW(a_error_zeroes, out_valid && status != ST_OK,
    src_address == 32'd0 && dest_port == 16'd0 && payload_length == 16'd0,
    "error result carries nonzero fields")
  `IUHP_ASSERT_NOW(a_ok_lengths, out_valid && status == ST_OK,
    payload_length + UDP_HDR == udp_length && payload_offset >= 7'd28,
    "inconsistent lengths on good result")
  `IUHP_ASSERT_NEXT(a_hold_result, out_valid && out_stall,
    out_valid && $stable(status), "stalled result lost or changed")

endmodule
`default_nettype wire
